// ----- src/bfa_pkg.sv -----
// Package for the bitfield access unit.
// Holds request codes, window constants and the byte-order helper.
// No dependencies.
`default_nettype none

package bfa_pkg;

  localparam int WORD_BYTES = 8;
  localparam int BYTE_W = 8;
  localparam int WORD_W = WORD_BYTES * BYTE_W;
  localparam int SIZE_W = 7;
  localparam int ADDR_W = 29;
  localparam int SHIFT_W = 6;
  localparam int WBYTES_W = 4;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Window sizes as log2 of the byte count.
  localparam logic [1:0] WIN_1 = 2'd0;
  localparam logic [1:0] WIN_2 = 2'd1;
  localparam logic [1:0] WIN_4 = 2'd2;
  localparam logic [1:0] WIN_8 = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  // Reverses the byte order of a full word.
  function automatic word_t byte_reverse(input word_t w);
    word_t r;
    r = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      r[BYTE_W*(WORD_BYTES-1-i) +: BYTE_W] = w[BYTE_W*i +: BYTE_W];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/bitfield_access_unit.sv -----
// Bitfield access unit: window geometry, field extract and field insert.
// Depends on bfa_pkg for codes, widths and the byte-order helper.
//
// Usage:
// Each input transfer carries a field position and size, a byte order, a get
// or put request, the container bytes and a value. Each input transfer gives
// exactly one output transfer, in order. The output carries the aligned
// window (start byte, byte count, low and high shifts), the field value and
// the updated container, or an error flag with zeroed geometry when the
// field size is zero or over WORD_W bits, or when no aligned window of at
// most MAX_WINDOW_BYTES bytes covers the field. The block has an input
// register stage and an output register stage with the whole computation
// between them, and it takes one item every cycle while the receiver does
// not stall. When the receiver stalls, the output register holds its result
// and the input stage keeps taking items until it too is full; in_ready then
// drops. A synchronous active-low reset empties both stages. No state
// survives between items.
`default_nettype none

module bitfield_access_unit import bfa_pkg::*; #(
  parameter int MAX_WINDOW_BYTES = 8,
  parameter int POS_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [POS_BITS-1:0]   in_bit_pos,
  input  wire logic [SIZE_W-1:0]     in_bit_size,
  input  wire logic                  in_big_endian,
  input  wire logic [WORD_W-1:0]     in_container_bytes,
  input  wire logic [WORD_W-1:0]     in_put_value,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic                  out_geom_error,
  output      logic [ADDR_W-1:0]     out_window_addr,
  output      logic [WBYTES_W-1:0]   out_window_bytes,
  output      logic [SHIFT_W-1:0]    out_low_shift,
  output      logic [SHIFT_W-1:0]    out_high_shift,
  output      logic [WORD_W-1:0]     out_field_value,
  output      logic [WORD_W-1:0]     out_new_container
);

  localparam int LOB_W = POS_BITS - 3;
  localparam int AW = (LOB_W > ADDR_W) ? LOB_W : ADDR_W;
  localparam logic ALLOW_2 = (MAX_WINDOW_BYTES >= 2);
  localparam logic ALLOW_4 = (MAX_WINDOW_BYTES >= 4);
  localparam logic ALLOW_8 = (MAX_WINDOW_BYTES >= 8);

  logic                s1_valid_r;
  logic                s1_req_r;
  logic [POS_BITS-1:0] s1_pos_r;
  logic [SIZE_W-1:0]   s1_size_r;
  logic                s1_be_r;
  word_t               s1_cont_r;
  word_t               s1_val_r;

  logic                out_valid_r;
  logic                geom_error_r;
  logic [ADDR_W-1:0]   window_addr_r;
  logic [WBYTES_W-1:0] window_bytes_r;
  logic [SHIFT_W-1:0]  low_shift_r;
  logic [SHIFT_W-1:0]  high_shift_r;
  word_t               field_value_r;
  word_t               new_container_r;

  logic                out_adv;
  logic                s1_adv;
  logic                in_xfer;

  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r  <= in_req_type;
      s1_pos_r  <= in_bit_pos;
      s1_size_r <= in_bit_size;
      s1_be_r   <= in_big_endian;
      s1_cont_r <= in_container_bytes;
      s1_val_r  <= in_put_value;
    end
  end

  // Window geometry.
  logic [2:0]       bit_off;
  logic [LOB_W-1:0] lob;
  logic [7:0]       end_bit;
  logic [4:0]       byte_cnt;
  logic             size_bad;
  logic             fit1, fit2, fit4, fit8;
  logic             win_ok;
  logic [1:0]       win_log2;
  logic [2:0]       lo_mask;
  logic [2:0]       lob_off;
  logic [LOB_W-1:0] lob_base;
  logic [AW-1:0]    base_ext;
  logic [WBYTES_W-1:0] win_bytes;
  logic [SHIFT_W-1:0]  les;
  logic [SIZE_W-1:0]   bes;
  logic             geom_error;

  assign bit_off  = s1_pos_r[2:0];
  assign lob      = s1_pos_r[POS_BITS-1:3];
  assign end_bit  = {5'd0, bit_off} + {1'b0, s1_size_r} - 8'd1;
  assign byte_cnt = {1'b0, end_bit[6:3]} + 5'd1;
  assign size_bad = (s1_size_r == '0) || (s1_size_r > SIZE_W'(WORD_W));

  assign fit1 = (byte_cnt == 5'd1);
  assign fit2 = ({4'd0, lob[0]} + byte_cnt) <= 5'd2;
  assign fit4 = ({3'd0, lob[1:0]} + byte_cnt) <= 5'd4;
  assign fit8 = ({2'd0, lob[2:0]} + byte_cnt) <= 5'd8;

  always_comb begin
    win_ok   = 1'b1;
    win_log2 = WIN_1;
    priority if (fit1) begin
      win_log2 = WIN_1;
    end else if (fit2 && ALLOW_2) begin
      win_log2 = WIN_2;
    end else if (fit4 && ALLOW_4) begin
      win_log2 = WIN_4;
    end else if (fit8 && ALLOW_8) begin
      win_log2 = WIN_8;
    end else begin
      win_ok = 1'b0;
    end
  end

  word_t win_mask;
  logic [SHIFT_W-1:0] rev_shift;

  always_comb begin
    unique case (win_log2)
      WIN_1: begin
        lo_mask   = 3'b000;
        win_mask  = word_t'(8'hff);
        rev_shift = SHIFT_W'(WORD_W - 8);
      end
      WIN_2: begin
        lo_mask   = 3'b001;
        win_mask  = word_t'(16'hffff);
        rev_shift = SHIFT_W'(WORD_W - 16);
      end
      WIN_4: begin
        lo_mask   = 3'b011;
        win_mask  = word_t'(32'hffff_ffff);
        rev_shift = SHIFT_W'(WORD_W - 32);
      end
      default: begin
        lo_mask   = 3'b111;
        win_mask  = '1;
        rev_shift = '0;
      end
    endcase
  end

  assign lob_off   = lob[2:0] & lo_mask;
  assign lob_base  = lob & ~{{(LOB_W-3){1'b0}}, lo_mask};
  assign base_ext  = AW'(lob_base);
  assign win_bytes = WBYTES_W'(1) << win_log2;
  assign les       = {lob_off, bit_off};
  assign bes       = {win_bytes, 3'b000} - ({1'b0, les} + s1_size_r);
  assign geom_error = size_bad || !win_ok;

  // Field extract and insert.
  word_t              rev_cont;
  word_t              gathered;
  logic [SHIFT_W-1:0] fshift;
  word_t              fmask;
  word_t              get_value;
  word_t              put_value;
  word_t              w_new;
  word_t              scattered;
  word_t              put_cont;

  assign rev_cont  = byte_reverse(s1_cont_r);
  assign gathered  = s1_be_r ? (rev_cont >> rev_shift) : (s1_cont_r & win_mask);
  assign fshift    = s1_be_r ? bes[SHIFT_W-1:0] : les;
  assign fmask     = s1_size_r[SIZE_W-1] ? '1 : ((word_t'(1) << s1_size_r[SHIFT_W-1:0])
                     - word_t'(1));
  assign get_value = (gathered >> fshift) & fmask;
  assign put_value = s1_val_r & fmask;
  assign w_new     = (gathered & ~(fmask << fshift)) | (put_value << fshift);
  assign scattered = s1_be_r ? byte_reverse(w_new << rev_shift) : (w_new & win_mask);
  assign put_cont  = (s1_cont_r & ~win_mask) | scattered;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      geom_error_r <= geom_error;
      if (geom_error) begin
        window_addr_r   <= '0;
        window_bytes_r  <= '0;
        low_shift_r     <= '0;
        high_shift_r    <= '0;
        field_value_r   <= '0;
        new_container_r <= s1_cont_r;
      end else begin
        window_addr_r   <= base_ext[ADDR_W-1:0];
        window_bytes_r  <= win_bytes;
        low_shift_r     <= les;
        high_shift_r    <= bes[SHIFT_W-1:0];
        field_value_r   <= (s1_req_r == REQ_PUT) ? put_value : get_value;
        new_container_r <= (s1_req_r == REQ_PUT) ? put_cont : s1_cont_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_geom_error    = geom_error_r;
  assign out_window_addr   = window_addr_r;
  assign out_window_bytes  = window_bytes_r;
  assign out_low_shift     = low_shift_r;
  assign out_high_shift    = high_shift_r;
  assign out_field_value   = field_value_r;
  assign out_new_container = new_container_r;

  a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_geom_error |->
      out_window_bytes == '0 && out_field_value == '0 && out_low_shift == '0)
    else $error("error result carries nonzero geometry or value");

  a_window_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_geom_error |-> $onehot(out_window_bytes))
    else $error("window byte count is not a power of two");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("empty input stage refuses a transfer");

endmodule

`default_nettype wire
